>>> src/servo_status_packet_parser_macros.svh
// ----------------------------------------------------------------------------
// servo status packet parser assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SERVO_STATUS_PACKET_PARSER_MACROS_SVH
`define SERVO_STATUS_PACKET_PARSER_MACROS_SVH

// same-cycle implication
`define SSPP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sspp assertion failed");

// next-cycle implication
`define SSPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sspp assertion failed");

`endif

>>> src/sspp_pkg.sv
// ----------------------------------------------------------------------------
// sspp_pkg
// types and codes shared by the status packet parser
// ----------------------------------------------------------------------------
package sspp_pkg;

  // input command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_HDR_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG     = 3'd2;
  localparam logic [2:0] ST_BODY_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_CHECKSUM     = 3'd4;
  localparam logic [2:0] ST_ID_MISMATCH  = 3'd5;
  localparam logic [2:0] ST_SERVO_ERROR  = 3'd6;

  localparam logic [15:0] WAIT_LIMIT_RESET = 16'd1000;
  localparam logic [7:0]  HEADER_BYTES     = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_HEAD = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_ERR  = 3'd4,
    PH_PAR  = 3'd5,
    PH_CHK  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0,
    CS_READ = 2'd1,
    CS_SEND = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] expected_id;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] servo_id;
    logic [7:0] error_flags;
    logic [7:0] param_byte;
    logic [3:0] param_index;
    logic       param_valid;
    logic       last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic step;  // apply the request on the input port
    logic rd;    // read the next stored parameter into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic single;  // request ends with one result
    logic run;     // request starts a run of parameters
    logic last;    // result in the output register closes the run
  } dp_sts_t;

endpackage

>>> src/sspp_ctrl.sv
// ----------------------------------------------------------------------------
// sspp_ctrl
// handshake controller: takes requests, sequences result reads and delivery
// ----------------------------------------------------------------------------
module sspp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sspp_pkg::dp_sts_t sts_i,
  output sspp_pkg::dp_cmd_t cmd_o
);
  import sspp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          if (sts_i.single) begin
            state_d = CS_SEND;
          end else if (sts_i.run) begin
            state_d = CS_READ;
          end
        end
      end
      CS_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = CS_SEND;
      end
      CS_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = sts_i.last ? CS_IDLE : CS_READ;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

>>> src/sspp_dp.sv
// ----------------------------------------------------------------------------
// sspp_dp
// parse datapath: packet fields, checksum, wait counter, parameter store
// ----------------------------------------------------------------------------
module sspp_dp #(
  parameter int MAX_LENGTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wait_limit_i,
  input  sspp_pkg::in_item_t  in_data_i,
  input  sspp_pkg::dp_cmd_t   cmd_i,
  output sspp_pkg::dp_sts_t   sts_o,
  output sspp_pkg::out_item_t out_data_o
);
  import sspp_pkg::*;

  localparam int StoreDepth = MAX_LENGTH - 2;
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int CntW       = $clog2(MAX_LENGTH);
  localparam logic [7:0] MaxLen = 8'(MAX_LENGTH);

  logic [15:0]     wait_limit_q;
  phase_e          phase_q, phase_d;
  logic [7:0]      want_id_q, want_id_d;
  logic [7:0]      got_id_q, got_id_d;
  logic [7:0]      pkt_length_q, pkt_length_d;
  logic [7:0]      servo_error_q, servo_error_d;
  logic [7:0]      sum_q, sum_d;
  logic [CntW-1:0] pcnt_q, pcnt_d;
  logic [15:0]     wait_q, wait_d;
  logic [1:0]      hdr_q, hdr_d;
  logic [CntW-1:0] emit_idx_q;
  logic [CntW-1:0] run_len_q;
  logic [7:0]      store_q [StoreDepth];
  out_item_t       out_q;

  logic [7:0]      rx;
  logic [7:0]      expected;
  logic [16:0]     tick_sum;
  logic [CntW-1:0] pcnt_inc;
  logic            res_single;
  logic            res_run;
  logic [2:0]      fail_status;
  logic            store_we;

  assign rx       = in_data_i.rx_byte;
  assign tick_sum = {1'b0, wait_q} + 17'd1;
  assign pcnt_inc = pcnt_q + 1'b1;
  // parameters that follow the current length byte
  assign expected     = (pkt_length_q >= HEADER_BYTES) ? pkt_length_q - HEADER_BYTES : 8'd0;

  always_comb begin
    phase_d       = phase_q;
    want_id_d     = want_id_q;
    got_id_d      = got_id_q;
    pkt_length_d  = pkt_length_q;
    servo_error_d = servo_error_q;
    sum_d         = sum_q;
    pcnt_d        = pcnt_q;
    wait_d        = wait_q;
    hdr_d         = hdr_q;
    res_single    = 1'b0;
    res_run       = 1'b0;
    fail_status   = ST_OK;
    store_we      = 1'b0;
    case (in_data_i.command)
      CMD_START: begin
        want_id_d     = in_data_i.expected_id;
        got_id_d      = '0;
        pkt_length_d  = '0;
        servo_error_d = '0;
        sum_d         = '0;
        pcnt_d        = '0;
        wait_d        = '0;
        hdr_d         = '0;
        phase_d       = PH_HEAD;
      end
      CMD_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (tick_sum > {1'b0, wait_limit_q}) begin
            res_single  = 1'b1;
            fail_status = (phase_q == PH_HEAD || phase_q == PH_ID || phase_q == PH_LEN)
                          ? ST_HDR_TIMEOUT : ST_BODY_TIMEOUT;
            phase_d     = PH_IDLE;
          end else begin
            wait_d = tick_sum[15:0];
          end
        end
      end
      CMD_BYTE: begin
        case (phase_q)
          PH_HEAD: begin
            hdr_d = hdr_q + 2'd1;
            if ({6'd0, hdr_d} >= HEADER_BYTES) begin
              phase_d = PH_ID;
            end
          end
          PH_ID: begin
            got_id_d = rx;
            sum_d    = rx;
            phase_d  = PH_LEN;
          end
          PH_LEN: begin
            pkt_length_d = rx;
            if (rx > MaxLen) begin
              res_single  = 1'b1;
              fail_status = ST_TOO_LONG;
              phase_d     = PH_IDLE;
            end else begin
              sum_d   = sum_q + rx;
              wait_d  = '0;
              phase_d = PH_ERR;
            end
          end
          PH_ERR: begin
            servo_error_d = rx;
            sum_d         = sum_q + rx;
            phase_d       = (expected == 8'd0) ? PH_CHK : PH_PAR;
          end
          PH_PAR: begin
            store_we = 1'b1;
            sum_d    = sum_q + rx;
            pcnt_d   = pcnt_inc;
            if (8'(pcnt_inc) >= expected) begin
              phase_d = PH_CHK;
            end
          end
          PH_CHK: begin
            phase_d    = PH_IDLE;
            res_single = 1'b1;
            if (~sum_q != rx) begin
              fail_status = ST_CHECKSUM;
            end else if (got_id_q != want_id_q) begin
              fail_status = ST_ID_MISMATCH;
            end else if (servo_error_q != 8'd0) begin
              fail_status = ST_SERVO_ERROR;
            end else if (pcnt_q != '0) begin
              res_single = 1'b0;
              res_run    = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_limit_q <= WAIT_LIMIT_RESET;
    end else if (cfg_we_i) begin
      wait_limit_q <= cfg_wait_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      want_id_q     <= '0;
      got_id_q      <= '0;
      pkt_length_q  <= '0;
      servo_error_q <= '0;
      sum_q         <= '0;
      pcnt_q        <= '0;
      wait_q        <= '0;
      hdr_q         <= '0;
      emit_idx_q    <= '0;
      run_len_q     <= '0;
    end else begin
      if (cmd_i.step) begin
        phase_q       <= phase_d;
        want_id_q     <= want_id_d;
        got_id_q      <= got_id_d;
        pkt_length_q  <= pkt_length_d;
        servo_error_q <= servo_error_d;
        sum_q         <= sum_d;
        pcnt_q        <= pcnt_d;
        wait_q        <= wait_d;
        hdr_q         <= hdr_d;
        if (res_run) begin
          emit_idx_q <= '0;
          run_len_q  <= pcnt_q;
        end
      end else if (cmd_i.rd) begin
        emit_idx_q <= emit_idx_q + 1'b1;
      end
    end
  end

  // parameter store, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && store_we) begin
      store_q[pcnt_q[AddrW-1:0]] <= rx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && res_single) begin
      out_q.status      <= fail_status;
      out_q.servo_id    <= got_id_q;
      out_q.error_flags <= servo_error_q;
      out_q.param_byte  <= '0;
      out_q.param_index <= '0;
      out_q.param_valid <= 1'b0;
      out_q.last        <= 1'b1;
    end else if (cmd_i.rd) begin
      out_q.status      <= ST_OK;
      out_q.servo_id    <= got_id_q;
      out_q.error_flags <= servo_error_q;
      out_q.param_byte  <= store_q[emit_idx_q[AddrW-1:0]];
      out_q.param_index <= 4'(emit_idx_q);
      out_q.param_valid <= 1'b1;
      out_q.last        <= ((emit_idx_q + 1'b1) == run_len_q);
    end
  end

  assign sts_o.single = res_single;
  assign sts_o.run    = res_run;
  assign sts_o.last   = out_q.last;
  assign out_data_o   = out_q;

endmodule

>>> src/servo_status_packet_parser.sv
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// parses one serial servo status packet per start request and reports it
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid_i / in_stall_o / in_data_i) carries requests:
//   start with the expected servo id, one received byte, or one wait tick
// - a request is taken at a clock edge with in_valid_i high and
//   in_stall_o low
// - output channel (out_valid_o / out_stall_i / out_data_o) carries results
// - a failure or an empty packet gives one result in the cycle after the
//   request; a good packet gives one result per parameter, each read from
//   the store into the output register and then held there while
//   out_stall_i is high
// - the parser holds in_stall_o high until the last result is taken;
//   a stalled result stays in the output register unchanged
// - cfg channel writes wait_limit (ready is always high); write it only
//   while the parser is idle
// - reset clears the controller and the parse state; wait_limit returns
//   to 1000 and the parameter store is left as is
// ----------------------------------------------------------------------------
module servo_status_packet_parser #(
  parameter int MAX_LENGTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sspp_pkg::in_item_t  in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sspp_pkg::out_item_t out_data_o,
  // wait limit write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_wait_limit_i
);
  import sspp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // register is always writable
  assign cfg_ready_o = 1'b1;

  // handshake controller
  sspp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // parse datapath with the parameter store
  sspp_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_wait_limit_i (cfg_wait_limit_i),
    .in_data_i        (in_data_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_data_o       (out_data_o)
  );

endmodule

>>> src/sspp_checker.sv
// ----------------------------------------------------------------------------
// sspp_checker
// port level checks for the status packet parser
// ----------------------------------------------------------------------------
`include "servo_status_packet_parser_macros.svh"

module sspp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sspp_pkg::out_item_t out_data_o
);
  import sspp_pkg::*;

  // stalled result holds
  `SSPP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // no request taken while a result is pending
  `SSPP_ASSERT_IMPL(a_stall_busy, clk_i, rst_ni, out_valid_o, in_stall_o)

  // a result without a parameter is always alone
  `SSPP_ASSERT_IMPL(a_single_last, clk_i, rst_ni, out_valid_o && !out_data_o.param_valid, out_data_o.last)

  // failures never carry parameters
  `SSPP_ASSERT_IMPL(a_fail_noparam, clk_i, rst_ni, out_valid_o && out_data_o.status != ST_OK, !out_data_o.param_valid)

endmodule

bind servo_status_packet_parser sspp_checker u_sspp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
